// File: src/tsf_pkg.sv
`timescale 1ns / 1ps
package tsf_pkg;

   localparam int VW      = 12;
   localparam int SLOPE_W = 29;
   localparam int FRAC_W  = 16;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ROW_L,
      ST_ROW_S,
      ST_ROW_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 start;
      logic signed [VW:0]   dx;
      logic signed [VW:0]   dy;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [SLOPE_W-1:0] quot;
   } div_rsp_type;

endpackage

// File: src/triangle_scanline_fill_core.sv
`timescale 1ns / 1ps
// Scanline triangle filler. One request transaction carries a triangle; the
// core sorts its vertices by y, finds the slopes of edges AB, AC and BC in turn with one
// shared serial divider, then walks the rows from the clipped top to the
// clipped bottom through the ROW_L, ROW_S and ROW_EVAL states for each row,
// pausing while the span receiver holds off. One span transaction comes out
// per visible row, top row first, the last with tlast; a fully clipped
// triangle gives one transaction with tuser low and tlast high.
// req_tready is high only between triangles. Frame size comes from the csr
// port; the user must write it only while the core is idle, and the core
// does not enforce this.
module triangle_scanline_fill_core #(
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WIDTH  = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // ax[11:0] ay[23:12] bx[35:24] by[47:36] cx[59:48] cy[71:60] colour[95:72]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // row[5:0] span_start[16:6] span_end[28:17] span_colour[52:29] zero[55:53]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   // span_valid[0]
   output logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);
   import tsf_pkg::*;

   localparam logic [6:0]  MaxH = 7'(MAX_HEIGHT);
   localparam logic [13:0] MaxW = 14'(MAX_WIDTH);
   localparam int PW = SLOPE_W + 14;

   function automatic logic signed [13:0] edge_col(logic signed [VW-1:0] base,
                                                   logic signed [PW-1:0] p);
      logic signed [PW:0] v;
      logic signed [PW:0] q;
      v = (PW+1)'(signed'({base, {FRAC_W{1'b0}}})) + (PW+1)'(p);
      q = v >>> FRAC_W;
      if (v[PW] && (v[FRAC_W-1:0] != '0)) q = q + 1;
      return q[13:0];
   endfunction

   state_type state_ff, state_in;
   logic [11:0] fw_ff;
   logic [6:0]  fh_ff;

   logic signed [VW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [23:0] colour_ff;
   logic signed [SLOPE_W-1:0] s_ab_ff, s_ac_ff, s_bc_ff;
   logic [1:0]  sel_ff;
   logic [5:0]  y_ff, yhi_ff;
   logic        empty_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [13:0]   xl_ff;
   logic [5:0]  pend_row_ff;
   logic [10:0] pend_lo_ff;
   logic [11:0] pend_hi_ff;
   logic        pend_valid_ff;
   logic        out_valid_ff, out_last_ff, out_user_ff;
   logic [5:0]  out_row_ff;
   logic [10:0] out_lo_ff;
   logic [11:0] out_hi_ff;
   logic [23:0] out_colour_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   tsf_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // sort network
   logic signed [VW-1:0] sax, say, sbx, sby, scx, scy, tx, ty;
   always_comb begin
      sax = ax_ff; say = ay_ff; sbx = bx_ff; sby = by_ff; scx = cx_ff; scy = cy_ff;
      tx = '0; ty = '0;
      if (say > sby) begin tx = sax; ty = say; sax = sbx; say = sby; sbx = tx; sby = ty; end
      if (sby > scy) begin tx = sbx; ty = sby; sbx = scx; sby = scy; scx = tx; scy = ty; end
      if (say > sby) begin tx = sax; ty = say; sax = sbx; say = sby; sbx = tx; sby = ty; end
   end

   logic [6:0] h_eff;
   logic signed [VW:0] ylo_s, yhi_s;
   always_comb begin
      h_eff = (fh_ff < MaxH) ? fh_ff : MaxH;
      ylo_s = (say > 0) ? (VW+1)'(say) : '0;
      yhi_s = ((VW+1)'(scy) < $signed({6'd0, h_eff}) - 13'sd1) ? (VW+1)'(scy)
            : $signed({6'd0, h_eff}) - 13'sd1;
   end

   // row datapath
   logic signed [13:0] ydiff_l, ydiff_s, xs, lo_s, hi_s, lo_c, hi_c, w_eff;
   logic               upper, vis, out_free, push_pend, push_last, push_none;
   logic signed [VW-1:0] sh_x, sh_y;
   logic signed [SLOPE_W-1:0] sh_slope;
   always_comb begin
      upper    = $signed({8'd0, y_ff}) < 14'(by_ff);
      sh_x     = upper ? ax_ff : bx_ff;
      sh_y     = upper ? ay_ff : by_ff;
      sh_slope = upper ? s_ab_ff : s_bc_ff;
      ydiff_l  = $signed({8'd0, y_ff}) - 14'(ay_ff);
      ydiff_s  = $signed({8'd0, y_ff}) - 14'(sh_y);
      xs       = edge_col(sh_x, prod_ff);
      lo_s     = (xl_ff < xs) ? xl_ff : xs;
      hi_s     = (xl_ff < xs) ? xs : xl_ff;
      w_eff    = ({2'b0, fw_ff} < MaxW) ? $signed({2'b0, fw_ff}) : $signed(MaxW);
      lo_c     = (lo_s < 0) ? '0 : lo_s;
      hi_c     = (hi_s > w_eff) ? w_eff : hi_s;
      vis      = lo_c < hi_c;
      out_free = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in      = state_ff;
      div_req.start = 1'b0;
      push_pend     = 1'b0;
      push_last     = 1'b0;
      push_none     = 1'b0;
      unique case (sel_ff)
         2'd0:    begin div_req.dx = 13'(bx_ff) - 13'(ax_ff);
                        div_req.dy = 13'(by_ff) - 13'(ay_ff); end
         2'd1:    begin div_req.dx = 13'(cx_ff) - 13'(ax_ff);
                        div_req.dy = 13'(cy_ff) - 13'(ay_ff); end
         default: begin div_req.dx = 13'(cx_ff) - 13'(bx_ff);
                        div_req.dy = 13'(cy_ff) - 13'(by_ff); end
      endcase
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_SORT;
         ST_SORT:      state_in = ST_DIV_START;
         ST_DIV_START: begin
            div_req.start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT:  if (div_rsp.done) begin
            if (sel_ff != 2'd2)  state_in = ST_DIV_START;
            else if (empty_ff)   state_in = ST_FINISH;
            else                 state_in = ST_ROW_L;
         end
         ST_ROW_L:     state_in = ST_ROW_S;
         ST_ROW_S:     state_in = ST_ROW_EVAL;
         ST_ROW_EVAL:  if (!(vis && pend_valid_ff && !out_free)) begin
            push_pend = vis && pend_valid_ff;
            state_in  = (y_ff == yhi_ff) ? ST_FINISH : ST_ROW_L;
         end
         ST_FINISH:    if (out_free) begin
            push_last = pend_valid_ff;
            push_none = !pend_valid_ff;
            state_in  = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 12'd2048;
         fh_ff <= 7'd64;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: fh_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         ax_ff <= req_tdata[11:0];  ay_ff <= req_tdata[23:12];
         bx_ff <= req_tdata[35:24]; by_ff <= req_tdata[47:36];
         cx_ff <= req_tdata[59:48]; cy_ff <= req_tdata[71:60];
         colour_ff <= req_tdata[95:72];
      end
      if (state_ff == ST_SORT) begin
         ax_ff <= sax; ay_ff <= say; bx_ff <= sbx;
         by_ff <= sby; cx_ff <= scx; cy_ff <= scy;
         empty_ff <= ylo_s > yhi_s;
         y_ff     <= ylo_s[5:0];
         yhi_ff   <= yhi_s[5:0];
         sel_ff   <= 2'd0;
      end
      if (state_ff == ST_DIV_WAIT && div_rsp.done) begin
         case (sel_ff)
            2'd0:    s_ab_ff <= div_rsp.quot;
            2'd1:    s_ac_ff <= div_rsp.quot;
            default: s_bc_ff <= div_rsp.quot;
         endcase
         sel_ff <= sel_ff + 2'd1;
      end
      if (state_ff == ST_ROW_L) prod_ff <= s_ac_ff * ydiff_l;
      if (state_ff == ST_ROW_S) begin
         xl_ff   <= edge_col(ax_ff, prod_ff);
         prod_ff <= sh_slope * ydiff_s;
      end
      if (state_ff == ST_ROW_EVAL && state_in != ST_ROW_EVAL) begin
         if (vis) begin
            pend_row_ff <= y_ff;
            pend_lo_ff  <= lo_c[10:0];
            pend_hi_ff  <= hi_c[11:0];
         end
         y_ff <= y_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == ST_ROW_EVAL && state_in != ST_ROW_EVAL && vis)
            pend_valid_ff <= 1'b1;
         else if (push_last)
            pend_valid_ff <= 1'b0;
         if (push_pend || push_last || push_none) out_valid_ff <= 1'b1;
         else if (rsp_tready)                      out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_pend || push_last) begin
         out_row_ff    <= pend_row_ff;
         out_lo_ff     <= pend_lo_ff;
         out_hi_ff     <= pend_hi_ff;
         out_colour_ff <= colour_ff;
         out_user_ff   <= 1'b1;
         out_last_ff   <= push_last;
      end else if (push_none) begin
         out_row_ff    <= '0;
         out_lo_ff     <= '0;
         out_hi_ff     <= '0;
         out_colour_ff <= '0;
         out_user_ff   <= 1'b0;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_colour_ff, out_hi_ff, out_lo_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast) else $error("clipped result not last");
   a_span_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> {1'b0, out_lo_ff} < out_hi_ff)
      else $error("empty span sent");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff) else $error("span left behind");

endmodule

// File: src/tsf_div.sv
`timescale 1ns / 1ps
module tsf_div (
   input  logic                clock,
   input  logic                reset,
   input  tsf_pkg::div_req_type req,
   output tsf_pkg::div_rsp_type rsp
);
   import tsf_pkg::*;

   localparam int QW = VW + FRAC_W;

   logic [QW-1:0]  q_ff, q_in;
   logic [VW-1:0]  rem_ff, rem_in;
   logic [VW-1:0]  div_ff;
   logic           neg_ff, zero_ff;
   logic [4:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [VW:0]    shifted, trial;
   logic           ge;
   logic [VW-1:0]  mag;

   always_comb begin
      mag     = req.dx[VW] ? VW'(-req.dx) : req.dx[VW-1:0];
      shifted = {rem_ff, q_ff[QW-1]};
      trial   = shifted - {1'b0, div_ff};
      ge      = shifted >= {1'b0, div_ff};
      q_in    = {q_ff[QW-2:0], ge};
      rem_in  = ge ? trial[VW-1:0] : shifted[VW-1:0];
      cnt_in  = cnt_ff - 5'd1;
      busy_in = busy_ff && (cnt_ff != 5'd1);
      done_in = busy_ff && (cnt_ff == 5'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 5'(QW);
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         q_ff    <= {mag, {FRAC_W{1'b0}}};
         rem_ff  <= '0;
         div_ff  <= req.dy[VW-1:0];
         neg_ff  <= req.dx[VW];
         zero_ff <= (req.dy <= 0);
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      rsp.done = done_ff;
      if (zero_ff)     rsp.quot = '0;
      else if (neg_ff) rsp.quot = -$signed({1'b0, q_ff});
      else             rsp.quot = $signed({1'b0, q_ff});
   end

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 5'd0) else $error("divider count underflow");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");

endmodule
